// ===== sv/tts_pkg.sv =====
// Shared types, constants and fixed-point helpers of the tridiagonal solver.
package tts_pkg;

    localparam int DEF_MAX_ROWS  = 64;
    localparam int DEF_FRAC_BITS = 32;

    localparam logic [63:0] SMAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SMIN = 64'h8000_0000_0000_0000;

    typedef struct packed {
        logic [63:0] lower_coef;
        logic [63:0] diag_coef;
        logic [63:0] upper_coef;
        logic [63:0] rhs_value;
        logic        last_row;
    } t_row;

    typedef struct packed {
        logic [63:0] solution;
        logic [5:0]  row_index;
        logic        last_value;
        logic        singular;
    } t_sol;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV_W,
        S_MUL_D,
        S_MUL_R,
        S_WRITE,
        S_BK_RD,
        S_BK_SEL,
        S_BK_MUL,
        S_BK_DIV,
        S_EM_RD,
        S_EM_LD,
        S_EM_OUT
    } t_state;

    function automatic logic [63:0] mag64(input logic [63:0] a);
        mag64 = a[63] ? (64'd0 - a) : a;
    endfunction

    // Apply sign to a 128-bit magnitude and saturate to 64 bits.
    function automatic logic [63:0] pack_sat(input logic neg, input logic [63:0] hi,
                                             input logic [63:0] lo);
        if (neg) begin
            pack_sat = (hi != 64'd0 || lo > SMIN) ? SMIN : (64'd0 - lo);
        end else begin
            pack_sat = (hi != 64'd0 || lo > SMAX) ? SMAX : lo;
        end
    endfunction

    function automatic logic [63:0] sat_sub(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] r;
        r = a - b;
        if (((a ^ b) & (a ^ r)) >> 63 != 64'd0) begin
            sat_sub = a[63] ? SMIN : SMAX;
        end else begin
            sat_sub = r;
        end
    endfunction

endpackage

// ===== sv/tts_mul.sv =====
// Fixed-point multiplier: four 32x32 partial products over successive cycles.
module tts_mul import tts_pkg::*; #(
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic        o_done,
    output logic [63:0] o_res
);

    logic [63:0]  r_ma, r_mb, r_prod, r_res;
    logic         r_neg, r_busy, r_done;
    logic [127:0] r_acc;
    logic [2:0]   r_step;
    logic [1:0]   r_pstep;
    logic [31:0]  ah, bh;
    logic [127:0] shifted, pshift;

    assign ah = r_step[0] ? r_ma[63:32] : r_ma[31:0];
    assign bh = r_step[1] ? r_mb[63:32] : r_mb[31:0];

    always_comb begin
        case (r_pstep)
            2'd0:    pshift = {64'd0, r_prod};
            2'd3:    pshift = {r_prod, 64'd0};
            default: pshift = {32'd0, r_prod, 32'd0};
        endcase
    end

    assign shifted = r_acc >> FRAC_BITS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= 3'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= 3'd0;
            end else if (r_busy) begin
                r_step <= r_step + 3'd1;
                if (r_step == 3'd5) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ma  <= mag64(i_a);
            r_mb  <= mag64(i_b);
            r_neg <= i_a[63] ^ i_b[63];
            r_acc <= 128'd0;
        end else if (r_busy) begin
            if (r_step < 3'd4) begin
                r_prod  <= 64'(ah) * 64'(bh);
                r_pstep <= r_step[1:0];
            end
            if (r_step >= 3'd1 && r_step <= 3'd4) begin
                r_acc <= r_acc + pshift;
            end
            if (r_step == 3'd5) begin
                r_res <= pack_sat(r_neg, shifted[127:64], shifted[63:0]);
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

// ===== sv/tts_div.sv =====
// Fixed-point divider: restoring, one quotient bit per cycle, saturating.
module tts_div import tts_pkg::*; #(
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic        o_done,
    output logic [63:0] o_res
);

    localparam int NW = 64 + FRAC_BITS;
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] r_num;
    logic [63:0]   r_rem, r_d, r_q, r_res;
    logic          r_ovf, r_neg, r_busy, r_done;
    logic [CW-1:0] r_cnt;
    logic [64:0]   rem2, diff;
    logic          ge;

    assign rem2 = {r_rem, r_num[NW-1]};
    assign ge   = rem2 >= {1'b0, r_d};
    assign diff = rem2 - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                if (i_b == 64'd0) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                end
            end else if (r_busy && r_cnt == CW'(0)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_res <= i_a[63] ? SMIN : SMAX;
            r_num <= {mag64(i_a), FRAC_BITS'(0)};
            r_d   <= mag64(i_b);
            r_neg <= i_a[63] ^ i_b[63];
            r_rem <= 64'd0;
            r_q   <= 64'd0;
            r_ovf <= 1'b0;
            r_cnt <= CW'(NW);
        end else if (r_busy) begin
            if (r_cnt != CW'(0)) begin
                r_rem <= ge ? diff[63:0] : rem2[63:0];
                r_q   <= {r_q[62:0], ge};
                r_ovf <= r_ovf | r_q[63];
                r_num <= r_num << 1;
                r_cnt <= r_cnt - CW'(1);
            end else begin
                r_res <= pack_sat(r_neg, {63'd0, r_ovf}, r_q);
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

// ===== sv/tridiagonal_thomas_solver_top.sv =====
// Top level of the tridiagonal (Thomas algorithm) solver.
// Each request is one row of a tridiagonal system in signed fixed point
// (Q32.32 by default). Forward elimination runs per row as it arrives: the
// ratio lower/previous pivot goes through a serial divider, then two products
// through the multiplier of four partial products; the first row skips both.
// The input stalls while a row is in work. On the row flagged last, back
// substitution runs from the last row up, one multiply and one divide per row
// (the last row skips the multiply), the solutions land in an on-chip store,
// and are then sent out in row order, one at a time, each held while the
// output stalls; the last one is flagged and every one carries the singular
// flag (some pivot was zero). Rows past MAX_ROWS are dropped; a dropped row
// flagged last still ends the system. Values saturate; a zero divisor gives
// full scale.
module tridiagonal_thomas_solver_top import tts_pkg::*; #(
    parameter int MAX_ROWS  = DEF_MAX_ROWS,
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_row i_row,
    output logic o_valid,
    input  logic i_stall,
    output t_sol o_sol
);

    localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW = $clog2(MAX_ROWS + 1);

    t_state r_state, n_state;

    // Row stores
    logic [63:0] piv_mem [MAX_ROWS];
    logic [63:0] rhs_mem [MAX_ROWS];
    logic [63:0] up_mem  [MAX_ROWS];
    logic [63:0] x_mem   [MAX_ROWS];

    logic [63:0] r_lower, r_diag, r_upper, r_rhs;
    logic        r_last;
    logic [63:0] r_w, r_d, r_r;
    logic [63:0] r_prev_up, r_prev_piv, r_prev_rhs;
    logic [CW-1:0] r_cnt;
    logic        r_zp;
    logic [AW-1:0] r_idx;
    logic [63:0] r_x, r_num;
    logic [63:0] r_rd_piv, r_rd_rhs, r_rd_up, r_rd_x;
    logic        r_issued;
    t_sol        r_sol;

    logic        mul_start, mul_done, div_start, div_done;
    logic [63:0] mul_a, mul_b, mul_res, div_a, div_b, div_res;
    logic        take, fwd_ok;
    logic [AW-1:0] last_idx;

    assign take     = i_valid && !o_stall;
    assign fwd_ok   = r_cnt < CW'(MAX_ROWS);
    assign last_idx = AW'(r_cnt - CW'(1));

    tts_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
        .i_clk, .i_rst_n,
        .i_start(mul_start), .i_a(mul_a), .i_b(mul_b),
        .o_done(mul_done), .o_res(mul_res)
    );

    tts_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk, .i_rst_n,
        .i_start(div_start), .i_a(div_a), .i_b(div_b),
        .o_done(div_done), .o_res(div_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        mul_start = 1'b0;
        div_start = 1'b0;
        mul_a     = r_w;
        mul_b     = r_prev_up;
        div_a     = r_lower;
        div_b     = r_prev_piv;
        unique case (r_state)
            S_IDLE: begin
                if (take) begin
                    if (fwd_ok) begin
                        n_state = (r_cnt == CW'(0)) ? S_WRITE : S_DIV_W;
                    end else if (i_row.last_row) begin
                        n_state = S_BK_RD;
                    end
                end
            end
            S_DIV_W: begin
                div_start = !r_issued;
                if (div_done) n_state = S_MUL_D;
            end
            S_MUL_D: begin
                mul_start = !r_issued;
                if (mul_done) n_state = S_MUL_R;
            end
            S_MUL_R: begin
                mul_start = !r_issued;
                mul_b     = r_prev_rhs;
                if (mul_done) n_state = S_WRITE;
            end
            S_WRITE: begin
                n_state = r_last ? S_BK_RD : S_IDLE;
            end
            S_BK_RD: begin
                n_state = S_BK_SEL;
            end
            S_BK_SEL: begin
                n_state = (r_idx == last_idx) ? S_BK_DIV : S_BK_MUL;
            end
            S_BK_MUL: begin
                mul_start = !r_issued;
                mul_a     = r_rd_up;
                mul_b     = r_x;
                if (mul_done) n_state = S_BK_DIV;
            end
            S_BK_DIV: begin
                div_start = !r_issued;
                div_a     = r_num;
                div_b     = r_rd_piv;
                if (div_done) n_state = (r_idx == AW'(0)) ? S_EM_RD : S_BK_RD;
            end
            S_EM_RD: begin
                n_state = S_EM_LD;
            end
            S_EM_LD: begin
                n_state = S_EM_OUT;
            end
            S_EM_OUT: begin
                if (!i_stall) n_state = (r_idx == last_idx) ? S_IDLE : S_EM_RD;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= CW'(0);
            r_zp      <= 1'b0;
            r_prev_up <= 64'd0;
            r_issued  <= 1'b0;
            r_idx     <= AW'(0);
        end else begin
            if (mul_start || div_start) r_issued <= 1'b1;
            else if (mul_done || div_done) r_issued <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (take && !fwd_ok && i_row.last_row) r_idx <= last_idx;
                end
                S_WRITE: begin
                    r_cnt     <= r_cnt + CW'(1);
                    r_prev_up <= r_upper;
                    if (r_d == 64'd0) r_zp <= 1'b1;
                    r_idx     <= AW'(r_cnt);
                end
                S_BK_DIV: begin
                    if (div_done && r_idx != AW'(0)) r_idx <= r_idx - AW'(1);
                end
                S_EM_OUT: begin
                    if (!i_stall) begin
                        if (r_idx == last_idx) begin
                            r_cnt     <= CW'(0);
                            r_zp      <= 1'b0;
                            r_prev_up <= 64'd0;
                            r_idx     <= AW'(0);
                        end else begin
                            r_idx <= r_idx + AW'(1);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (take) begin
                    r_lower <= i_row.lower_coef;
                    r_diag  <= i_row.diag_coef;
                    r_upper <= i_row.upper_coef;
                    r_rhs   <= i_row.rhs_value;
                    r_last  <= i_row.last_row;
                    r_d     <= i_row.diag_coef;
                    r_r     <= i_row.rhs_value;
                end
            end
            S_DIV_W:  if (div_done) r_w <= div_res;
            S_MUL_D:  if (mul_done) r_d <= sat_sub(r_diag, mul_res);
            S_MUL_R:  if (mul_done) r_r <= sat_sub(r_rhs, mul_res);
            S_WRITE: begin
                r_prev_piv <= r_d;
                r_prev_rhs <= r_r;
            end
            S_BK_SEL: r_num <= r_rd_rhs;
            S_BK_MUL: if (mul_done) r_num <= sat_sub(r_num, mul_res);
            S_BK_DIV: if (div_done) r_x <= div_res;
            S_EM_LD: begin
                r_sol.solution   <= r_rd_x;
                r_sol.row_index  <= 6'(r_idx);
                r_sol.last_value <= (r_idx == last_idx);
                r_sol.singular   <= r_zp;
            end
            default: ;
        endcase
    end

    // Stores: one write port, registered read at r_idx
    always_ff @(posedge i_clk) begin
        if (r_state == S_WRITE) begin
            piv_mem[AW'(r_cnt)] <= r_d;
            rhs_mem[AW'(r_cnt)] <= r_r;
            up_mem[AW'(r_cnt)]  <= r_upper;
        end
        if (r_state == S_BK_DIV && div_done) begin
            x_mem[r_idx] <= div_res;
        end
        r_rd_piv <= piv_mem[r_idx];
        r_rd_rhs <= rhs_mem[r_idx];
        r_rd_up  <= up_mem[r_idx];
        r_rd_x   <= x_mem[r_idx];
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = (r_state == S_EM_OUT);
    assign o_sol   = r_sol;

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the tridiagonal Thomas solver top level.
module tb;
    import tts_pkg::*;

    // Q32.32 unity and the row capacity of the default build
    localparam logic [63:0] ONE      = 64'h0000_0001_0000_0000;
    localparam int          FRACW    = DEF_FRAC_BITS;
    localparam int          CAPACITY = DEF_MAX_ROWS;
    localparam int          N_ROWS   = 320;
    localparam int          N_REPORT = 10;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    t_row i_row = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    t_sol o_sol;

    tridiagonal_thomas_solver_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_row   (i_row),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_sol   (o_sol)
    );

    always #5 i_clk = ~i_clk;

    // Solver image: elimination store and per-system state
    logic [63:0] elim_pivot [CAPACITY];
    logic [63:0] elim_rhs   [CAPACITY];
    logic [63:0] elim_upper [CAPACITY];
    logic [63:0] carried_upper;
    int          loaded_rows;
    bit          pivot_zero;

    t_sol solution_q[$];

    int rows_sent;
    int sols_seen;
    int systems_done;
    int singular_systems;
    int overflow_systems;
    int mismatches;

    function automatic logic [63:0] fx_abs(input logic [63:0] a);
        return a[63] ? (64'd0 - a) : a;
    endfunction

    // Sign a 128-bit magnitude and clamp to the 64-bit range.
    function automatic logic [63:0] fx_clamp(input bit neg, input logic [127:0] m);
        if (neg) return (m[127:64] != 0 || m[63:0] > SMIN) ? SMIN : (64'd0 - m[63:0]);
        return (m[127:64] != 0 || m[63:0] > SMAX) ? SMAX : m[63:0];
    endfunction

    function automatic logic [63:0] fx_times(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, fx_abs(a)} * {64'd0, fx_abs(b)};
        return fx_clamp(a[63] ^ b[63], p >> FRACW);
    endfunction

    function automatic logic [63:0] fx_over(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] num;
        if (b == 64'd0) return a[63] ? SMIN : SMAX;
        num = {64'd0, fx_abs(a)} << FRACW;
        return fx_clamp(a[63] ^ b[63], num / {64'd0, fx_abs(b)});
    endfunction

    function automatic logic [63:0] fx_minus(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] r;
        r = a - b;
        if ((a[63] ^ b[63]) && (a[63] ^ r[63])) return a[63] ? SMIN : SMAX;
        return r;
    endfunction

    // Eliminate one accepted row; on the last row, back-substitute and
    // queue the solutions in row order.
    task automatic solve_row(input t_row r);
        logic [63:0] w, d, rr, x, num;
        logic [63:0] sol_buf [CAPACITY];
        t_sol s;
        int i, n;
        if (loaded_rows < CAPACITY) begin
            i = loaded_rows;
            if (i == 0) begin
                d  = r.diag_coef;
                rr = r.rhs_value;
            end else begin
                w  = fx_over(r.lower_coef, elim_pivot[i-1]);
                d  = fx_minus(r.diag_coef, fx_times(w, carried_upper));
                rr = fx_minus(r.rhs_value, fx_times(w, elim_rhs[i-1]));
            end
            elim_pivot[i] = d;
            elim_rhs[i]   = rr;
            elim_upper[i] = r.upper_coef;
            if (d == 64'd0) pivot_zero = 1'b1;
            carried_upper = r.upper_coef;
            loaded_rows   = i + 1;
        end
        if (!r.last_row) return;
        n = loaded_rows;
        x = 64'd0;
        for (i = n - 1; i >= 0; i--) begin
            num = elim_rhs[i];
            if (i + 1 < n) num = fx_minus(num, fx_times(elim_upper[i], x));
            x = fx_over(num, elim_pivot[i]);
            sol_buf[i] = x;
        end
        for (i = 0; i < n; i++) begin
            s.solution   = sol_buf[i];
            s.row_index  = i[5:0];
            s.last_value = (i + 1 == n);
            s.singular   = pivot_zero;
            solution_q.push_back(s);
        end
        systems_done++;
        if (pivot_zero) singular_systems++;
        carried_upper = 64'd0;
        loaded_rows   = 0;
        pivot_zero    = 1'b0;
    endtask

    // Short gaps mostly, now and then a long one.
    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 92) return $urandom_range(1, 4);
        return $urandom_range(15, 60);
    endfunction

    // Offer one request and hold it until accepted; valid stays high
    // straight into the next request when there is no gap.
    task automatic offer_row(input t_row r);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_row   <= r;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        rows_sent++;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Signed value of magnitude below lim_units (integer part) plus fraction.
    function automatic logic [63:0] rand_fx(input int lim_units);
        logic [63:0] v;
        v = {32'd0, $urandom_range(0, lim_units - 1)} << 32 | {32'd0, $urandom};
        return $urandom_range(0, 1) ? (64'd0 - v) : v;
    endfunction

    // Well-formed row: dominant diagonal, moderate off-diagonals and rhs.
    // A slice of rows is fully random noise so every bit toggles.
    function automatic t_row make_row(input bit last);
        t_row r;
        logic [63:0] dg;
        if ($urandom_range(0, 99) < 15) begin
            r.lower_coef = rand64();
            r.diag_coef  = rand64();
            r.upper_coef = rand64();
            r.rhs_value  = rand64();
        end else begin
            dg = ({32'd0, $urandom_range(2, 8)} << 32) | {32'd0, $urandom};
            r.diag_coef  = $urandom_range(0, 1) ? (64'd0 - dg) : dg;
            r.lower_coef = rand_fx(1);
            r.upper_coef = rand_fx(1);
            r.rhs_value  = rand_fx(16);
        end
        r.last_row = last;
        return r;
    endfunction

    // Directed table: most single-row systems carry a typed answer; the
    // other systems are left to the predictor.
    typedef struct {
        t_row        row;
        bit          typed;
        logic [63:0] sol;
        bit          sing;
    } t_case;

    t_case directed[$];

    function automatic t_case mk(input logic [63:0] lo, input logic [63:0] dg,
                                 input logic [63:0] up, input logic [63:0] rh,
                                 input bit last, input bit typed,
                                 input logic [63:0] sol, input bit sing);
        t_case c;
        c.row   = '{lower_coef: lo, diag_coef: dg, upper_coef: up,
                    rhs_value: rh, last_row: last};
        c.typed = typed;
        c.sol   = sol;
        c.sing  = sing;
        return c;
    endfunction

    // Output check: compare each accepted solution against the oldest
    // expectation, field by field.
    always @(posedge i_clk) begin
        t_sol e;
        if (i_rst_n && o_valid && !i_stall) begin
            sols_seen++;
            if (solution_q.size() == 0) begin
                mismatches++;
                if (mismatches <= N_REPORT)
                    $display("unexpected solution row %0d value %h",
                             o_sol.row_index, o_sol.solution);
            end else begin
                e = solution_q.pop_front();
                if (o_sol.solution !== e.solution || o_sol.row_index !== e.row_index ||
                    o_sol.last_value !== e.last_value || o_sol.singular !== e.singular) begin
                    mismatches++;
                    if (mismatches <= N_REPORT)
                        $display("solution mismatch: exp row %0d x %h last %b sing %b, got row %0d x %h last %b sing %b",
                                 e.row_index, e.solution, e.last_value, e.singular,
                                 o_sol.row_index, o_sol.solution, o_sol.last_value,
                                 o_sol.singular);
                end
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off while rows keep coming
    // so the solver backs up and stalls its input.
    initial begin
        bit held;
        int p;
        held = 1'b0;
        @(posedge i_rst_n);
        forever begin
            p = $urandom_range(0, 99);
            if (!held && sols_seen >= 30) begin
                held = 1'b1;
                i_stall <= 1'b1;
                repeat (2000) @(posedge i_clk);
            end else if (p < 60) begin
                i_stall <= 1'b0;
                @(posedge i_clk);
            end else if (p < 92) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
            end else begin
                i_stall <= 1'b1;
                repeat ($urandom_range(10, 40)) @(posedge i_clk);
            end
        end
    end

    // Main stimulus
    initial begin
        t_case c;
        t_sol  s;
        int    len, k;
        bit    overflow_done;
        overflow_done = 1'b0;
        carried_upper = 64'd0;
        loaded_rows   = 0;
        pivot_zero    = 1'b0;

        // single-row systems: plain, zero pivot by sign of rhs, saturation
        directed.push_back(mk(SMIN, ONE, SMAX, 2*ONE, 1, 1, 2*ONE, 0));
        directed.push_back(mk(0, 0, 0, 5*ONE, 1, 1, SMAX, 1));
        directed.push_back(mk(0, 0, 0, 64'd0 - ONE, 1, 1, SMIN, 1));
        directed.push_back(mk(0, 0, 0, 0, 1, 1, SMAX, 1));
        directed.push_back(mk(SMAX, 64'd1, SMIN, SMAX, 1, 1, SMAX, 0));
        directed.push_back(mk(0, 64'd0 - ONE, 0, 3*ONE, 1, 1, 64'd0 - 3*ONE, 0));
        directed.push_back(mk(SMAX, SMIN, SMAX, SMIN, 1, 0, 0, 0));
        // three-row well-conditioned system
        directed.push_back(mk(0, 4*ONE, ONE, ONE, 0, 0, 0, 0));
        directed.push_back(mk(ONE, 4*ONE, ONE, 2*ONE, 0, 0, 0, 0));
        directed.push_back(mk(ONE, 4*ONE, 0, 3*ONE, 1, 0, 0, 0));
        // second pivot eliminated to zero
        directed.push_back(mk(0, ONE, ONE, ONE, 0, 0, 0, 0));
        directed.push_back(mk(ONE, ONE, 0, ONE, 1, 0, 0, 0));
        // zero first pivot feeds a saturated ratio forward
        directed.push_back(mk(0, 0, ONE, ONE, 0, 0, 0, 0));
        directed.push_back(mk(64'd0 - ONE, ONE, 0, ONE, 1, 0, 0, 0));
        // extremes throughout a two-row system
        directed.push_back(mk(SMIN, SMAX, SMIN, SMAX, 0, 0, 0, 0));
        directed.push_back(mk(SMAX, SMIN, SMAX, SMIN, 1, 0, 0, 0));

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[j]) begin
            c = directed[j];
            offer_row(c.row);
            if (c.typed) begin
                s = '{solution: c.sol, row_index: 6'd0, last_value: 1'b1,
                      singular: c.sing};
                solution_q.push_back(s);
                loaded_rows = 0;
                carried_upper = 64'd0;
                pivot_zero = 1'b0;
                systems_done++;
                if (c.sing) singular_systems++;
            end else begin
                solve_row(c.row);
            end
        end

        // Random systems, mostly short; one overruns the row store.
        while (rows_sent < N_ROWS) begin
            if (!overflow_done && rows_sent > 150) begin
                overflow_done = 1'b1;
                len = CAPACITY + 2;
                overflow_systems++;
            end else begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 14)
                                                  : $urandom_range(1, 6);
            end
            for (k = 0; k < len; k++) begin
                c.row = make_row(k == len - 1);
                offer_row(c.row);
                solve_row(c.row);
            end
        end
        i_valid <= 1'b0;

        while (solution_q.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);

        $display("covered %0d rows in %0d systems (%0d singular, %0d over capacity)",
                 rows_sent, systems_done, singular_systems, overflow_systems);
        $display("checked %0d solution values, %0d mismatching", sols_seen, mismatches);
        if (mismatches == 0 && solution_q.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #20_000_000;
        $display("timeout with %0d solutions outstanding", solution_q.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule
